// ----- rtl/ssudi_pkg.sv -----
package ssudi_pkg;

    localparam int VAL_W         = 32;
    localparam int OP_W          = 3;
    localparam int KIND_W        = 3;
    localparam int SET_DEPTH_DEF = 16;

    localparam logic [OP_W-1:0] OP_ADD_A  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_B  = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
    localparam logic [OP_W-1:0] OP_UNION  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIFF   = 3'd4;
    localparam logic [OP_W-1:0] OP_INTER  = 3'd5;

    localparam logic [KIND_W-1:0] KIND_STORED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DUP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MEMBER  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEARED = 3'd5;

    // per-chain control from the sequencer
    typedef struct packed {
        logic shift;   // rotate one place toward the head
        logic load;    // write the tail slot selected by the count
    } t_chain_ctl;

endpackage

// ----- rtl/ssudi_cell.sv -----
module ssudi_cell
    import ssudi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic             i_load,
    input  logic [VAL_W-1:0] i_load_val,
    input  logic [VAL_W-1:0] i_next,
    input  logic [VAL_W-1:0] i_probe,
    input  logic             i_valid,
    output logic [VAL_W-1:0] o_val,
    output logic             o_hit
);

    logic [VAL_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_next;
        end else if (i_load) begin
            r_val <= i_load_val;
        end
    end

    assign o_val = r_val;
    assign o_hit = i_valid && (r_val == i_probe);

endmodule

// ----- rtl/ssudi_chain.sv -----
module ssudi_chain
    import ssudi_pkg::*;
#(
    parameter  int DEPTH = SET_DEPTH_DEF,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  t_chain_ctl       i_ctl,
    input  logic [VAL_W-1:0] i_load_val,
    input  logic [VAL_W-1:0] i_probe,
    input  logic [CW-1:0]    i_count,
    output logic [VAL_W-1:0] o_head,
    output logic             o_hit
);

    logic [VAL_W-1:0] w_val [DEPTH];
    logic [DEPTH-1:0] w_hit;

    // ring of cells: a full rotation of DEPTH shifts restores the order
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ssudi_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (i_ctl.shift),
            .i_load     (i_ctl.load && (i_count == CW'(g))),
            .i_load_val (i_load_val),
            .i_next     (w_val[(g + 1) % DEPTH]),
            .i_probe    (i_probe),
            .i_valid    (CW'(g) < i_count),
            .o_val      (w_val[g]),
            .o_hit      (w_hit[g])
        );
    end

    assign o_head = w_val[0];
    assign o_hit  = |w_hit;

endmodule

// ----- rtl/small_set_union_difference_intersection.sv -----
// Two small signed sets, A and B, each a ring of SET_DEPTH cells kept in insertion
// order. Raise start with i_op and i_value while busy is low. Add and clear leave
// busy low, so a new command can follow at once; their single result appears on
// the cycle after acceptance. A query holds busy high while its rings rotate one
// cell per cycle and each head entry is checked against the other set by a parallel
// compare: difference and intersection rotate ring A, union rotates ring A and then
// ring B. Results come one per o_strobe pulse, one cycle each, and cannot be
// stalled; o_last marks the final result of a command, which for a query shows on
// the cycle busy falls. Unused op codes are accepted and give no result.
module small_set_union_difference_intersection
    import ssudi_pkg::*;
#(
    parameter  int SET_DEPTH = SET_DEPTH_DEF,
    localparam int CW        = $clog2(SET_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OP_W-1:0]         i_op,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_strobe,
    output logic signed [VAL_W-1:0] o_element,
    output logic [KIND_W-1:0]       o_kind,
    output logic                    o_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN_A = 2'd1;
    localparam logic [1:0] ST_RUN_B = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CW-1:0]     r_k, n_k;
    logic [OP_W-1:0]   r_op, n_op;
    logic [CW-1:0]     r_cnt_a, n_cnt_a;
    logic [CW-1:0]     r_cnt_b, n_cnt_b;
    logic [VAL_W-1:0]  r_pend, n_pend;
    logic              r_pend_v, n_pend_v;
    logic              r_strobe, n_strobe;
    logic [VAL_W-1:0]  r_element, n_element;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic              r_last, n_last;

    t_chain_ctl        w_ctl_a, w_ctl_b;
    logic [VAL_W-1:0]  w_head_a, w_head_b;
    logic [VAL_W-1:0]  w_probe_a, w_probe_b;
    logic              w_hit_a, w_hit_b;
    logic              w_emit;
    logic [VAL_W-1:0]  w_emit_val;

    // in idle both rings see the incoming value for the duplicate check
    assign w_probe_a = (r_state == ST_IDLE) ? i_value : w_head_b;
    assign w_probe_b = (r_state == ST_IDLE) ? i_value : w_head_a;

    ssudi_chain #(.DEPTH(SET_DEPTH)) u_chain_a (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl_a),
        .i_load_val (i_value),
        .i_probe    (w_probe_a),
        .i_count    (r_cnt_a),
        .o_head     (w_head_a),
        .o_hit      (w_hit_a)
    );

    ssudi_chain #(.DEPTH(SET_DEPTH)) u_chain_b (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl_b),
        .i_load_val (i_value),
        .i_probe    (w_probe_b),
        .i_count    (r_cnt_b),
        .o_head     (w_head_b),
        .o_hit      (w_hit_b)
    );

    always_comb begin
        w_emit     = 1'b0;
        w_emit_val = w_head_a;
        if (r_state == ST_RUN_A) begin
            if (r_k < r_cnt_a) begin
                case (r_op)
                    OP_UNION: w_emit = 1'b1;
                    OP_DIFF:  w_emit = !w_hit_b;
                    OP_INTER: w_emit = w_hit_b;
                    default:  w_emit = 1'b0;
                endcase
            end
        end else if (r_state == ST_RUN_B) begin
            w_emit     = (r_k < r_cnt_b) && !w_hit_a;
            w_emit_val = w_head_b;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_op      = r_op;
        n_cnt_a   = r_cnt_a;
        n_cnt_b   = r_cnt_b;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_strobe  = 1'b0;
        n_element = '0;
        n_kind    = KIND_STORED;
        n_last    = 1'b0;
        w_ctl_a   = '0;
        w_ctl_b   = '0;

        // one result behind the scan, so the final one can carry last
        if (w_emit) begin
            if (r_pend_v) begin
                n_strobe  = 1'b1;
                n_element = r_pend;
                n_kind    = KIND_MEMBER;
            end
            n_pend   = w_emit_val;
            n_pend_v = 1'b1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_op)
                        OP_ADD_A: begin
                            n_strobe  = 1'b1;
                            n_element = i_value;
                            n_last    = 1'b1;
                            if (w_hit_a) begin
                                n_kind = KIND_DUP;
                            end else if (r_cnt_a == CW'(SET_DEPTH)) begin
                                n_kind = KIND_FULL;
                            end else begin
                                n_kind        = KIND_STORED;
                                w_ctl_a.load  = 1'b1;
                                n_cnt_a       = r_cnt_a + 1'b1;
                            end
                        end
                        OP_ADD_B: begin
                            n_strobe  = 1'b1;
                            n_element = i_value;
                            n_last    = 1'b1;
                            if (w_hit_b) begin
                                n_kind = KIND_DUP;
                            end else if (r_cnt_b == CW'(SET_DEPTH)) begin
                                n_kind = KIND_FULL;
                            end else begin
                                n_kind        = KIND_STORED;
                                w_ctl_b.load  = 1'b1;
                                n_cnt_b       = r_cnt_b + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt_a  = '0;
                            n_cnt_b  = '0;
                            n_strobe = 1'b1;
                            n_kind   = KIND_CLEARED;
                            n_last   = 1'b1;
                        end
                        OP_UNION, OP_DIFF, OP_INTER: begin
                            n_op     = i_op;
                            n_k      = '0;
                            n_pend_v = 1'b0;
                            n_state  = ST_RUN_A;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN_A: begin
                w_ctl_a.shift = 1'b1;
                n_k           = r_k + 1'b1;
                if (r_k == CW'(SET_DEPTH - 1)) begin
                    n_k     = '0;
                    n_state = (r_op == OP_UNION) ? ST_RUN_B : ST_FLUSH;
                end
            end
            ST_RUN_B: begin
                w_ctl_b.shift = 1'b1;
                n_k           = r_k + 1'b1;
                if (r_k == CW'(SET_DEPTH - 1)) begin
                    n_k     = '0;
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                if (r_pend_v) begin
                    n_element = r_pend;
                    n_kind    = KIND_MEMBER;
                end else begin
                    n_kind = KIND_EMPTY;
                end
                n_pend_v = 1'b0;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_op      <= n_op;
        r_pend    <= n_pend;
        r_element <= n_element;
        r_kind    <= n_kind;
        r_last    <= n_last;
    end

    assign busy      = (r_state != ST_IDLE);
    assign o_strobe  = r_strobe;
    assign o_element = r_element;
    assign o_kind    = r_kind;
    assign o_last    = r_last;

endmodule

// ----- rtl/ssudi_checker.sv -----
module ssudi_checker
    import ssudi_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [OP_W-1:0]         i_op,
    input logic                    o_strobe,
    input logic signed [VAL_W-1:0] o_element,
    input logic [KIND_W-1:0]       o_kind,
    input logic                    o_last
);

    // a query always ends with a final result as busy drops
    a_query_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_strobe && o_last)
        else $error("query finished without a final result");

    // more results pending means the query is still running
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final result while idle");

    // add and clear give exactly one final result on the next cycle
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_op == OP_ADD_A || i_op == OP_ADD_B || i_op == OP_CLEAR)
        |=> o_strobe && o_last && !busy)
        else $error("add or clear result missing");

    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_EMPTY || o_kind == KIND_CLEARED)
        |-> o_last && (o_element == 0))
        else $error("empty or cleared marker malformed");

endmodule

bind small_set_union_difference_intersection ssudi_checker u_ssudi_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_op      (i_op),
    .o_strobe  (o_strobe),
    .o_element (o_element),
    .o_kind    (o_kind),
    .o_last    (o_last)
);

// ----- tb/small_set_union_difference_intersection_tb.sv -----
module small_set_union_difference_intersection_tb
    import ssudi_pkg::*;
();

    localparam int DEPTH          = SET_DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 40;
    localparam int N_ROWS         = 27;
    localparam int MAX_REPORTS    = 10;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    typedef struct {
        logic signed [VAL_W-1:0] element;
        logic [KIND_W-1:0]       kind;
        logic                    last;
    } t_result;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
        int                      reps;      // fill rows: value, value+1, ...
        bit                      typed;     // single result written out below
        logic [KIND_W-1:0]       kind;
        logic signed [VAL_W-1:0] element;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [OP_W-1:0]         i_op;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_strobe;
    logic signed [VAL_W-1:0] o_element;
    logic [KIND_W-1:0]       o_kind;
    logic                    o_last;

    // mirror of both sets, index 0 is A and 1 is B
    logic signed [VAL_W-1:0] set_mirror [2][DEPTH];
    int                      set_fill [2];

    t_result owed_results [$];
    t_row    script [N_ROWS];
    int      mismatches   = 0;
    int      issued_items = 0;
    bit      no_idle      = 1'b0;

    small_set_union_difference_intersection #(.SET_DEPTH(DEPTH)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_op      (i_op),
        .i_value   (i_value),
        .o_strobe  (o_strobe),
        .o_element (o_element),
        .o_kind    (o_kind),
        .o_last    (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit holds_value(input int side, input logic signed [VAL_W-1:0] v);
        for (int i = 0; i < set_fill[side]; i++)
            if (set_mirror[side][i] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Works out the results one accepted transaction causes and queues them.
    task automatic predict_results(input logic [OP_W-1:0] op,
                                   input logic signed [VAL_W-1:0] val);
        t_result run [$];
        t_result r;
        int      side;
        r.last = 1'b0;
        if (op == OP_ADD_A || op == OP_ADD_B) begin
            side      = (op == OP_ADD_B) ? 1 : 0;
            r.element = val;
            if (holds_value(side, val)) begin
                r.kind = KIND_DUP;
            end else if (set_fill[side] >= DEPTH) begin
                r.kind = KIND_FULL;
            end else begin
                set_mirror[side][set_fill[side]] = val;
                set_fill[side]++;
                r.kind = KIND_STORED;
            end
            run.push_back(r);
        end else if (op == OP_CLEAR) begin
            set_fill[0] = 0;
            set_fill[1] = 0;
            r.element   = '0;
            r.kind      = KIND_CLEARED;
            run.push_back(r);
        end else if (op == OP_UNION || op == OP_DIFF || op == OP_INTER) begin
            r.kind = KIND_MEMBER;
            for (int i = 0; i < set_fill[0]; i++) begin
                r.element = set_mirror[0][i];
                if (op == OP_UNION || holds_value(1, r.element) == (op == OP_INTER))
                    run.push_back(r);
            end
            if (op == OP_UNION)
                for (int i = 0; i < set_fill[1]; i++) begin
                    r.element = set_mirror[1][i];
                    if (!holds_value(0, r.element))
                        run.push_back(r);
                end
            if (run.size() == 0) begin
                r.element = '0;
                r.kind    = KIND_EMPTY;
                run.push_back(r);
            end
        end
        for (int i = 0; i < run.size(); i++) begin
            r      = run[i];
            r.last = (i == run.size() - 1);
            owed_results.push_back(r);
        end
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_op    <= op;
        i_value <= val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_results(op, val);
        if (op <= OP_INTER)
            issued_items++;
    endtask

    // hold off until every queued result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (owed_results.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : watch_results
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected transaction: element %0d kind %0d last %0b",
                             o_element, o_kind, o_last);
            end else begin
                want = owed_results.pop_front();
                if (o_element !== want.element || o_kind !== want.kind
                        || o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: element %0d/%0d kind %0d/%0d last %0b/%0b (exp/act)",
                                 want.element, o_element, want.kind, o_kind,
                                 want.last, o_last);
                end
            end
        end
    end

    initial begin : stimulus
        int                      random_base;
        int                      n_adds;
        int                      n_queries;
        int                      span;
        int                      r;
        logic signed [VAL_W-1:0] base;
        logic signed [VAL_W-1:0] val;
        logic [OP_W-1:0]         op;
        t_result                 typed_res;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_op        = OP_ADD_A;
        i_value     = '0;
        set_fill[0] = 0;
        set_fill[1] = 0;

        script = '{
            '{OP_UNION,  32'sd0,            1,     1'b1, KIND_EMPTY,   32'sd0},
            '{OP_DIFF,   32'sd0,            1,     1'b1, KIND_EMPTY,   32'sd0},
            '{OP_INTER,  32'sd0,            1,     1'b1, KIND_EMPTY,   32'sd0},
            '{OP_ADD_A,  32'sh7FFF_FFFF,    1,     1'b1, KIND_STORED,  32'sh7FFF_FFFF},
            '{OP_ADD_A,  32'sh8000_0000,    1,     1'b1, KIND_STORED,  32'sh8000_0000},
            '{OP_ADD_A,  32'sh8000_0000,    1,     1'b1, KIND_DUP,     32'sh8000_0000},
            '{OP_DIFF,   32'sd0,            1,     1'b0, KIND_MEMBER,  32'sd0},
            '{OP_ADD_B,  32'shFFFF_FFFF,    1,     1'b1, KIND_STORED,  32'shFFFF_FFFF},
            '{OP_ADD_B,  32'sh7FFF_FFFF,    1,     1'b1, KIND_STORED,  32'sh7FFF_FFFF},
            '{OP_UNION,  32'sd0,            1,     1'b0, KIND_MEMBER,  32'sd0},
            '{OP_INTER,  32'sd0,            1,     1'b0, KIND_MEMBER,  32'sd0},
            '{OP_DIFF,   32'sd0,            1,     1'b0, KIND_MEMBER,  32'sd0},
            '{OP_SPARE6, 32'sh5A5A_5A5A,    1,     1'b0, KIND_MEMBER,  32'sd0},
            '{OP_SPARE7, 32'shA5A5_A5A5,    1,     1'b0, KIND_MEMBER,  32'sd0},
            '{OP_CLEAR,  32'sh1234_5678,    1,     1'b1, KIND_CLEARED, 32'sd0},
            '{OP_ADD_A,  32'sd100,          DEPTH, 1'b0, KIND_STORED,  32'sd0},
            '{OP_ADD_A,  32'sd100,          1,     1'b1, KIND_DUP,     32'sd100},
            '{OP_ADD_A,  32'sh7FFF_FFFF,    1,     1'b1, KIND_FULL,    32'sh7FFF_FFFF},
            '{OP_ADD_B,  32'sd84,           DEPTH, 1'b0, KIND_STORED,  32'sd0},
            '{OP_ADD_B,  32'sd0,            1,     1'b1, KIND_FULL,    32'sd0},
            '{OP_UNION,  32'sd0,            1,     1'b0, KIND_MEMBER,  32'sd0},
            '{OP_INTER,  32'sd0,            1,     1'b1, KIND_EMPTY,   32'sd0},
            '{OP_CLEAR,  32'sd0,            1,     1'b1, KIND_CLEARED, 32'sd0},
            '{OP_ADD_A,  32'sd0,            1,     1'b1, KIND_STORED,  32'sd0},
            '{OP_ADD_B,  32'sd0,            1,     1'b1, KIND_STORED,  32'sd0},
            '{OP_DIFF,   32'sd0,            1,     1'b1, KIND_EMPTY,   32'sd0},
            '{OP_INTER,  32'sd0,            1,     1'b0, KIND_MEMBER,  32'sd0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < N_ROWS; row++)
            for (int k = 0; k < script[row].reps; k++) begin
                issue(script[row].op, script[row].value + k);
                if (script[row].typed) begin
                    // the written-out result stands in for the predicted one
                    typed_res.element = script[row].element;
                    typed_res.kind    = script[row].kind;
                    typed_res.last    = 1'b1;
                    owed_results[owed_results.size() - 1] = typed_res;
                end
            end
        drain();

        // episodes: mostly a clear, a burst of adds from a narrow value window, then queries
        random_base = issued_items;
        while (issued_items - random_base < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) != 0)
                issue(OP_CLEAR, $urandom);
            span   = $urandom_range(0, 1) ? $urandom_range(2, 12) : $urandom_range(20, 60);
            base   = $urandom;
            n_adds = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 40)
                                                 : $urandom_range(0, 10);
            for (int k = 0; k < n_adds; k++) begin
                op  = $urandom_range(0, 1) ? OP_ADD_A : OP_ADD_B;
                val = ($urandom_range(0, 19) == 0) ? $urandom : base + $urandom_range(0, span);
                issue(op, val);
            end
            n_queries = $urandom_range(1, 4);
            for (int k = 0; k < n_queries; k++) begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    op = OP_W'($urandom_range(OP_SPARE6, OP_SPARE7));
                else if (r == 1)
                    op = OP_CLEAR;
                else
                    op = OP_W'($urandom_range(OP_UNION, OP_INTER));
                issue(op, $urandom);
            end
            if ($urandom_range(0, 3) == 0)
                drain();
        end

        start <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("small_set_union_difference_intersection_tb: PASS");
        else
            $display("small_set_union_difference_intersection_tb: FAIL");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("small_set_union_difference_intersection_tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ssudi_pkg.sv
rtl/ssudi_cell.sv
rtl/ssudi_chain.sv
rtl/small_set_union_difference_intersection.sv
rtl/ssudi_checker.sv
tb/small_set_union_difference_intersection_tb.sv
